### sv/dltm_pkg.sv
// ----------------------------------------------------------------------------
// dltm_pkg
// Shared constants, sort network tables and stage enables for the
// trimmed-mean delay line.
// ----------------------------------------------------------------------------
package dltm_pkg;

	localparam int unsigned DELAY_DEPTH_DEF = 200;
	localparam int unsigned SAMPLE_BITS_DEF = 24;

	// samples in the sort window
	localparam int unsigned WINDOW = 8;

	// 19-comparator, 6-layer sorting network for eight values.
	// Entries up to CX_SPLIT-1 are the first three layers.
	localparam int unsigned CX_COUNT = 19;
	localparam int unsigned CX_SPLIT = 12;

	localparam logic [2:0] CX_LO [CX_COUNT] = '{
		3'd0, 3'd1, 3'd4, 3'd5,
		3'd0, 3'd1, 3'd2, 3'd3,
		3'd0, 3'd2, 3'd4, 3'd6,
		3'd2, 3'd3,
		3'd1, 3'd3,
		3'd1, 3'd3, 3'd5
	};
	localparam logic [2:0] CX_HI [CX_COUNT] = '{
		3'd2, 3'd3, 3'd6, 3'd7,
		3'd4, 3'd5, 3'd6, 3'd7,
		3'd1, 3'd3, 3'd5, 3'd7,
		3'd4, 3'd5,
		3'd4, 3'd6,
		3'd2, 3'd4, 3'd6
	};

	// load enables for the stages downstream of the delay memory
	typedef struct packed {
		logic tap;  // window shift register
		logic mid;  // after the first half of the network
		logic fin;  // result register
	} stage_en_t;

endpackage

### sv/dltm_delay.sv
// ----------------------------------------------------------------------------
// dltm_delay
// Circular delay memory of DELAY_DEPTH-8 entries with registered read.
// A full flag stands in for clearing: unwritten entries read as zero.
// ----------------------------------------------------------------------------
module dltm_delay #(
	parameter int unsigned DELAY_DEPTH = dltm_pkg::DELAY_DEPTH_DEF,
	parameter int unsigned SAMPLE_BITS = dltm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] value_s1
);
	import dltm_pkg::*;

	localparam int unsigned LEN  = DELAY_DEPTH - WINDOW;
	localparam int unsigned AW   = (LEN > 1) ? $clog2(LEN) : 1;
	localparam logic [AW-1:0] LAST = AW'(LEN - 1);

	logic signed [SAMPLE_BITS-1:0] mem [LEN];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic [AW-1:0]                 wp_q;
	logic                          full_q;
	logic                          full_s1;

	// read-before-write: rd_s1 gets the sample delayed by LEN requests
	always_ff @(posedge clk) begin
		if (load) begin
			rd_s1     <= mem[wp_q];
			mem[wp_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			full_q  <= 1'b0;
			full_s1 <= 1'b0;
		end else if (load) begin
			full_s1 <= full_q;
			if (wp_q == LAST) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	assign value_s1 = full_s1 ? rd_s1 : '0;

endmodule

### sv/dltm_trim.sv
// ----------------------------------------------------------------------------
// dltm_trim
// Eight-tap window, two-stage sorting network and sum of the middle four.
// ----------------------------------------------------------------------------
module dltm_trim #(
	parameter int unsigned SAMPLE_BITS = dltm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dltm_pkg::stage_en_t           en,
	input  logic signed [SAMPLE_BITS-1:0] value_s1,
	output logic signed [SAMPLE_BITS+1:0] trimmed_mean
);
	import dltm_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;

	logic signed [SB-1:0]   taps_q [WINDOW];
	logic signed [SB-1:0]   half   [WINDOW];
	logic signed [SB-1:0]   net_s3 [WINDOW];
	logic signed [SB+1:0]   sum;
	logic signed [SB+1:0]   mean_s4;

	// window: the eight oldest samples, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) taps_q[i] <= '0;
		end else if (en.tap) begin
			taps_q[0] <= value_s1;
			for (int i = 1; i < WINDOW; i++) taps_q[i] <= taps_q[i-1];
		end
	end

	// layers one to three
	always_comb begin
		logic signed [SB-1:0] t [WINDOW];
		logic signed [SB-1:0] s;
		s = '0;
		for (int i = 0; i < WINDOW; i++) t[i] = taps_q[i];
		for (int k = 0; k < CX_SPLIT; k++) begin
			if (t[CX_LO[k]] > t[CX_HI[k]]) begin
				s           = t[CX_LO[k]];
				t[CX_LO[k]] = t[CX_HI[k]];
				t[CX_HI[k]] = s;
			end
		end
		for (int i = 0; i < WINDOW; i++) half[i] = t[i];
	end

	always_ff @(posedge clk) begin
		if (en.mid) begin
			for (int i = 0; i < WINDOW; i++) net_s3[i] <= half[i];
		end
	end

	// layers four to six, then keep ranks two to five
	always_comb begin
		logic signed [SB-1:0] t [WINDOW];
		logic signed [SB-1:0] s;
		s = '0;
		for (int i = 0; i < WINDOW; i++) t[i] = net_s3[i];
		for (int k = CX_SPLIT; k < CX_COUNT; k++) begin
			if (t[CX_LO[k]] > t[CX_HI[k]]) begin
				s           = t[CX_LO[k]];
				t[CX_LO[k]] = t[CX_HI[k]];
				t[CX_HI[k]] = s;
			end
		end
		sum = {{2{t[2][SB-1]}}, t[2]} + {{2{t[3][SB-1]}}, t[3]}
		    + {{2{t[4][SB-1]}}, t[4]} + {{2{t[5][SB-1]}}, t[5]};
	end

	always_ff @(posedge clk) begin
		if (en.fin) mean_s4 <= sum;
	end

	assign trimmed_mean = mean_s4;

endmodule

### sv/delay_line_trimmed_mean_top.sv
// ----------------------------------------------------------------------------
// delay_line_trimmed_mean_top
// Gyro delay line with an eight-sample trimmed mean on its oldest samples.
//
// Usage:
//   Input channel (in_valid/in_ready, sample) takes one signed sample per
//   request. Output channel (out_valid/out_ready, trimmed_mean) returns one
//   result per request: the sum of the middle four of the eight samples
//   delayed by DELAY_DEPTH-8 .. DELAY_DEPTH-1 requests, i.e. their mean in
//   quarter-LSB units.
//   An accepted request passes the memory read, window, half network and
//   result registers before it shows on out_valid. Throughput: one
//   request per cycle while out_ready is high, set by the single-port delay
//   memory taking one write and one read per cycle and a four-stage pipe.
//   Stalls: each stage has its own valid flag, so bubbles close up while
//   out_ready is low; in_ready drops only once all four stages are full.
//   Reset: arst_n clears the pipe, the window and the write pointer. The
//   memory itself is not cleared; a full flag makes entries not yet written
//   since reset read as zero, so start-up results include those zeros.
// ----------------------------------------------------------------------------
module delay_line_trimmed_mean_top #(
	parameter int unsigned DELAY_DEPTH = dltm_pkg::DELAY_DEPTH_DEF,
	parameter int unsigned SAMPLE_BITS = dltm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS+1:0] trimmed_mean
);
	import dltm_pkg::*;

	// stage occupancy
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	// a stage can take new data when empty or when it moves on
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic load_s1;
	stage_en_t en;
	logic signed [SAMPLE_BITS-1:0] value_s1;

	assign rdy_s4  = !vld_s4 || out_ready;
	assign rdy_s3  = !vld_s3 || rdy_s4;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;

	assign in_ready = rdy_s1;
	assign load_s1  = in_valid && rdy_s1;
	assign en       = '{
		tap: vld_s1 && rdy_s2,
		mid: vld_s2 && rdy_s3,
		fin: vld_s3 && rdy_s4
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= load_s1 || (vld_s1 && !en.tap);
			vld_s2 <= en.tap  || (vld_s2 && !en.mid);
			vld_s3 <= en.mid  || (vld_s3 && !en.fin);
			vld_s4 <= en.fin  || (vld_s4 && !out_ready);
		end
	end

	// delay memory: hands over the sample entering the window
	dltm_delay #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_s1),
		.sample   (sample),
		.value_s1 (value_s1)
	);

	// window, sort and trimmed sum
	dltm_trim #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_trim (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.value_s1     (value_s1),
		.trimmed_mean (trimmed_mean)
	);

	assign out_valid = vld_s4;

	// empty output stage means the whole pipe can move: input must be open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s4 |-> in_ready)
		else $error("in_ready low with output stage empty");

	// with every stage full and the receiver stalled, no request may enter
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && !out_ready) |-> !in_ready)
		else $error("request accepted into a full pipe");

	// a stalled result keeps the stage behind it occupied
	a_hold_behind_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && vld_s4 && !out_ready) |=> vld_s3)
		else $error("stage three lost its item during a stall");

endmodule

### sim/delay_line_trimmed_mean_top_tb.sv
// ----------------------------------------------------------------------------
// delay_line_trimmed_mean_top_tb
// Self-checking bench for the gyro delay line with trimmed mean. Requests
// come from a queue filled up front and are driven by a clocked driver. A
// behavioural copy of the delay store predicts every result. A clocked
// monitor compares each result in order, under random idling on both
// channels.
// ----------------------------------------------------------------------------
module delay_line_trimmed_mean_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = dltm_pkg::DELAY_DEPTH_DEF;
	localparam int unsigned SB    = dltm_pkg::SAMPLE_BITS_DEF;
	localparam int unsigned TAPS  = dltm_pkg::WINDOW;

	localparam int unsigned N_RANDOM  = 1950;
	localparam int unsigned PHASE_LEN = 650;

	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	// one pending request plus the idling it runs under
	typedef struct {
		logic signed [SB-1:0] value;
		bit                   drain_first;  // hold off until all results are back
		int unsigned          tx_idle;      // sender idle, percent
		int unsigned          rx_stall;     // receiver stall, percent
	} gyro_req_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic signed [SB-1:0] sample       = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic signed [SB+1:0] trimmed_mean;

	gyro_req_t            pending_reqs[$];
	logic signed [SB+1:0] mean_q[$];

	// predictor state: a copy of the delay store and its write pointer
	logic signed [SB-1:0] gyro_hist [DEPTH];
	int unsigned          hist_wr;

	int unsigned          rx_stall_pct = 0;
	int unsigned          mismatches   = 0;

	delay_line_trimmed_mean_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trimmed_mean (trimmed_mean)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// sort eight, drop two at each end, sum the middle four
	function automatic logic signed [SB+1:0] trimmed_sum(input longint win [TAPS]);
		longint t [TAPS];
		longint sw;
		longint acc;
		t = win;
		acc = 0;
		for (int i = 0; i < TAPS - 1; i++) begin
			for (int j = 0; j < TAPS - 1 - i; j++) begin
				if (t[j] > t[j+1]) begin
					sw = t[j];
					t[j] = t[j+1];
					t[j+1] = sw;
				end
			end
		end
		for (int i = 2; i < 6; i++) begin
			acc += t[i];
		end
		return acc[SB+1:0];
	endfunction

	// write the request into the store, then the eight oldest entries follow
	// the write pointer in circular order
	task automatic predict_mean(input logic signed [SB-1:0] s);
		longint win [TAPS];
		gyro_hist[hist_wr] = s;
		for (int i = 0; i < TAPS; i++) begin
			win[i] = longint'(gyro_hist[(hist_wr + 1 + i) % DEPTH]);
		end
		mean_q.push_back(trimmed_sum(win));
		hist_wr = (hist_wr + 1) % DEPTH;
	endtask

	// random sample with a bias towards extremes, small values and repeats
	function automatic logic signed [SB-1:0] pick_sample(input logic signed [SB-1:0] prev);
		logic signed [SB-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				v = SB'($urandom());
			end
			4: begin
				v = S_MAX;
			end
			5: begin
				v = S_MIN;
			end
			6: begin
				v = SB'($signed($urandom_range(32)) - 16);
			end
			7: begin
				// runs of equal values give ties in the sort
				v = prev;
			end
			8: begin
				v = $urandom_range(1) ? S_MAX - SB'($urandom_range(3))
					: S_MIN + SB'($urandom_range(3));
			end
			default: begin
				v = $urandom_range(1) ? $signed(SB'($urandom_range(255)))
					: -$signed(SB'($urandom_range(255)));
			end
		endcase
		return v;
	endfunction

	// driver: one nonblocking write of in_valid per edge
	always @(posedge clk) begin : drive_req
		gyro_req_t r;
		logic      nxt_valid;
		logic      fire;
		if (arst_n) begin
			fire = in_valid && in_ready;
			if (fire) begin
				predict_mean(sample);
			end
			nxt_valid = in_valid && !fire;
			if ((!in_valid || fire) && pending_reqs.size() != 0) begin
				r = pending_reqs[0];
				if (r.drain_first && mean_q.size() != 0) begin
					// wait for the pipe to empty before this request
				end else if ($urandom_range(99) < r.tx_idle) begin
					// idle cycle
				end else begin
					r = pending_reqs.pop_front();
					nxt_valid = 1'b1;
					sample <= r.value;
					rx_stall_pct <= r.rx_stall;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_mean
		logic signed [SB+1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (mean_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: got %0d", trimmed_mean);
					end
				end else begin
					want = mean_q.pop_front();
					if (trimmed_mean !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("trimmed_mean mismatch: expected %0d, got %0d",
								want, trimmed_mean);
						end
					end
				end
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// stimulus, reset and end of run
	initial begin : stim
		gyro_req_t            r;
		logic signed [SB-1:0] directed [$];
		logic signed [SB-1:0] prev;
		hist_wr = 0;
		for (int i = 0; i < DEPTH; i++) begin
			gyro_hist[i] = '0;
		end

		// directed part: extremes, sign boundary, bit patterns and ties
		directed = '{S_MAX, S_MIN, 24'sd0, -24'sd1, 24'sd1, S_MAX, S_MAX, S_MAX,
			S_MIN, S_MIN, S_MIN, 24'sh555555, -24'sh555556, 24'sh2AAAAA,
			24'sh7F0000, -24'sh7F0001, 24'sd5, 24'sd5, 24'sd5, 24'sd5,
			-24'sd5, -24'sd5, 24'sh000100, S_MAX, S_MIN};
		foreach (directed[i]) begin
			r.value = directed[i];
			r.drain_first = 1'b0;
			r.tx_idle = 6;
			r.rx_stall = 65;
			pending_reqs.push_back(r);
		end

		prev = '0;
		for (int k = 0; k < N_RANDOM; k++) begin
			r.value = pick_sample(prev);
			prev = r.value;
			r.drain_first = (k == 2 * PHASE_LEN) || (k == 2 * PHASE_LEN + 300);
			if (k < PHASE_LEN) begin
				r.tx_idle = 6;
				r.rx_stall = 65;
			end else if (k < 2 * PHASE_LEN) begin
				r.tx_idle = 65;
				r.rx_stall = 6;
			end else begin
				r.tx_idle = 0;
				r.rx_stall = 0;
			end
			pending_reqs.push_back(r);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (mean_q.size() != 0) begin
			@(posedge clk);
		end
		// wait out any trailing results before the final check
		repeat (10) @(posedge clk);

		mismatches += mean_q.size();
		if (mismatches == 0) begin
			$display("[delay_line_trimmed_mean_top] OK");
		end else begin
			$display("[delay_line_trimmed_mean_top] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400us;
		$display("[delay_line_trimmed_mean_top] ERROR");
		$finish;
	end

endmodule
